// ===== rtl/gspt_pkg.sv =====
// Shared types, constants and the sqrt(2) threshold helper for the recoder.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package gspt_pkg;

   // Fixed field widths of a result word
   localparam int POWER_WIDTH      = 5;
   localparam int COUNT_FIELD_WIDTH = 6;
   localparam int LIMIT_WIDTH      = 5;

   // Internal exponent arithmetic width, wide enough for any legal configuration
   localparam int EXP_WIDTH = 8;

   // term_limit after reset
   localparam logic [LIMIT_WIDTH-1:0] TERM_LIMIT_RESET = 5'd8;

   // Entries held between front and back
   localparam int QUEUE_DEPTH = 2;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_FIND = 3'b010,
      ST_STEP = 3'b100
   } engine_state_type;

   // Fixed-width part of one result word
   typedef struct packed {
      logic [COUNT_FIELD_WIDTH-1:0] fraction_bits;
      logic [COUNT_FIELD_WIDTH-1:0] integer_bits;
      logic                         last_digit;
      logic                         no_digit;
      logic                         digit_negative;
      logic [POWER_WIDTH-1:0]       digit_power;
   } result_meta_type;

   // floor(2^k * sqrt(2)) with an exact integer remainder; elaboration use only
   function automatic logic [63:0] sqrt2_floor(input int k);
      logic [63:0] t;
      logic [63:0] rem;
      logic [63:0] r4;
      logic [63:0] cand;
      t   = 64'd1;
      rem = 64'd1;
      for (int j = 0; j < k; j++) begin
         r4   = rem << 2;
         cand = (t << 2) + 64'd1;
         if (r4 >= cand) begin
            t   = (t << 1) + 64'd1;
            rem = r4 - cand;
         end else begin
            t   = t << 1;
            rem = r4;
         end
      end
      return t;
   endfunction

endpackage

// ===== rtl/gspt_front.sv =====
// Front end: classifies an incoming word into sign, magnitude, zero flag and limit.
// Depends on gspt_pkg.
module gspt_front #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_TERMS   = 16,
   parameter int CNT_WIDTH   = $clog2(MAX_TERMS + 1)
) (
   input  logic [VALUE_WIDTH-1:0]             value,
   input  logic [gspt_pkg::LIMIT_WIDTH-1:0]   term_limit,
   output logic [CNT_WIDTH+VALUE_WIDTH+1:0]   entry
);

   logic                   sign;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   zero;
   logic [CNT_WIDTH-1:0]   limit;
   logic [6:0]             limit_wide;

   // sign / magnitude split; the most negative value maps to 2^(W-1) unsigned
   assign sign = value[VALUE_WIDTH-1];
   assign mag  = sign ? (~value + VALUE_WIDTH'(1)) : value;
   assign zero = (value == '0);

   // clamp the digit limit to 1..MAX_TERMS
   assign limit_wide = 7'(term_limit);
   always_comb begin
      if (limit_wide == 7'd0) begin
         limit = CNT_WIDTH'(1);
      end else if (limit_wide > 7'(MAX_TERMS)) begin
         limit = CNT_WIDTH'(MAX_TERMS);
      end else begin
         limit = limit_wide[CNT_WIDTH-1:0];
      end
   end

   assign entry = {limit, zero, sign, mag};

endmodule

// ===== rtl/gspt_queue.sv =====
// Small register queue decoupling the front end from the digit engine.
// Depends on gspt_pkg for its depth.
module gspt_queue #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_WIDTH = (gspt_pkg::QUEUE_DEPTH > 1) ? $clog2(gspt_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_WIDTH = $clog2(gspt_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [gspt_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;

   assign push_ready = (fill_ff != FILL_WIDTH'(gspt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(gspt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(gspt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/gspt_engine.sv =====
// Back end: iterates greedy signed power-of-two digits and holds the output register.
// Depends on gspt_pkg.
module gspt_engine #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16,
   parameter int MAX_TERMS     = 16,
   parameter int CNT_WIDTH     = $clog2(MAX_TERMS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  logic [CNT_WIDTH+VALUE_WIDTH+1:0]  q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gspt_pkg::result_meta_type         rsp_meta,
   output logic [VALUE_WIDTH+1:0]            rsp_approx
);

   localparam int KW  = $clog2(VALUE_WIDTH);
   localparam int BW  = $clog2(VALUE_WIDTH + 1);
   localparam int EW  = gspt_pkg::EXP_WIDTH;
   localparam int SW  = VALUE_WIDTH + 2;
   localparam int CFW = gspt_pkg::COUNT_FIELD_WIDTH;

   // threshold table floor(2^k * sqrt(2))
   logic [VALUE_WIDTH-1:0] thr_tab [VALUE_WIDTH];
   for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_thr
      assign thr_tab[g] = VALUE_WIDTH'(gspt_pkg::sqrt2_floor(g));
   end

   gspt_pkg::engine_state_type state_ff, state_in;
   logic                       sign_ff, sign_in;
   logic [VALUE_WIDTH-1:0]     mag_ff, mag_in;
   logic                       zero_ff, zero_in;
   logic [CNT_WIDTH-1:0]       limit_ff, limit_in;
   logic [CNT_WIDTH-1:0]       cnt_ff, cnt_in;
   logic [KW-1:0]              k_ff, k_in;
   logic signed [SW-1:0]       sum_ff, sum_in;
   logic signed [EW-1:0]       first_ff, first_in;
   logic                       valid_ff, valid_in;
   gspt_pkg::result_meta_type  meta_ff, meta_in;
   logic [SW-1:0]              approx_ff, approx_in;

   logic                       out_free;
   logic [KW-1:0]              k_found;
   logic                       big;
   logic [BW-1:0]              b;
   logic [VALUE_WIDTH:0]       mag_up;
   logic [VALUE_WIDTH:0]       mag_diff;
   logic [VALUE_WIDTH-1:0]     mag_new;
   logic signed [SW-1:0]       pow_b;
   logic signed [SW-1:0]       sum_new;
   logic signed [EW-1:0]       p;
   logic signed [EW-1:0]       p_first;
   logic signed [EW-1:0]       ibits;
   logic signed [EW-1:0]       fbits;
   logic [CNT_WIDTH-1:0]       cnt_next;
   logic                       is_last;

   assign out_free = !valid_ff || rsp_ready;

   // leading one of the magnitude
   always_comb begin
      k_found = '0;
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         if (mag_ff[i]) begin
            k_found = KW'(i);
         end
      end
   end

   // one digit: threshold pick, residue and running-sum update
   always_comb begin
      big      = (mag_ff > thr_tab[k_ff]);
      b        = big ? (BW'(k_ff) + BW'(1)) : BW'(k_ff);
      mag_up   = (VALUE_WIDTH + 1)'(1) << b;
      mag_diff = big ? (mag_up - {1'b0, mag_ff}) : ({1'b0, mag_ff} - mag_up);
      mag_new  = mag_diff[VALUE_WIDTH-1:0];
      pow_b    = SW'(1) << b;
      sum_new  = sign_ff ? (sum_ff - pow_b) : (sum_ff + pow_b);
      p        = EW'(b) - EW'(FRACTION_BITS);
      p_first  = (cnt_ff == '0) ? p : first_ff;
      ibits    = p_first + EW'(2);
      fbits    = EW'(0) - p;
      cnt_next = cnt_ff + CNT_WIDTH'(1);
      is_last  = (mag_new == '0) || (cnt_next == limit_ff);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      sign_in   = sign_ff;
      mag_in    = mag_ff;
      zero_in   = zero_ff;
      limit_in  = limit_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      sum_in    = sum_ff;
      first_in  = first_ff;
      valid_in  = out_free ? 1'b0 : valid_ff;
      meta_in   = meta_ff;
      approx_in = approx_ff;
      q_pop     = 1'b0;
      unique case (state_ff)
         gspt_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               mag_in   = q_data[VALUE_WIDTH-1:0];
               sign_in  = q_data[VALUE_WIDTH];
               zero_in  = q_data[VALUE_WIDTH+1];
               limit_in = q_data[CNT_WIDTH+VALUE_WIDTH+1:VALUE_WIDTH+2];
               cnt_in   = '0;
               sum_in   = '0;
               state_in = gspt_pkg::ST_FIND;
            end
         end
         gspt_pkg::ST_FIND: begin
            if (zero_ff) begin
               // zero input: a single empty result
               if (out_free) begin
                  valid_in           = 1'b1;
                  meta_in            = '0;
                  meta_in.no_digit   = 1'b1;
                  meta_in.last_digit = 1'b1;
                  approx_in          = '0;
                  state_in           = gspt_pkg::ST_IDLE;
               end
            end else begin
               k_in     = k_found;
               state_in = gspt_pkg::ST_STEP;
            end
         end
         gspt_pkg::ST_STEP: begin
            if (out_free) begin
               valid_in               = 1'b1;
               meta_in                = '0;
               meta_in.digit_power    = p[gspt_pkg::POWER_WIDTH-1:0];
               meta_in.digit_negative = sign_ff;
               meta_in.last_digit     = is_last;
               approx_in              = '0;
               if (is_last) begin
                  meta_in.integer_bits  = ibits[CFW-1:0];
                  meta_in.fraction_bits = fbits[CFW-1:0];
                  approx_in             = sum_new;
               end
               mag_in   = mag_new;
               sign_in  = big ? !sign_ff : sign_ff;
               sum_in   = sum_new;
               first_in = p_first;
               cnt_in   = cnt_next;
               state_in = is_last ? gspt_pkg::ST_IDLE : gspt_pkg::ST_FIND;
            end
         end
         default: begin
            state_in = gspt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gspt_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sign_ff   <= sign_in;
      mag_ff    <= mag_in;
      zero_ff   <= zero_in;
      limit_ff  <= limit_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      sum_ff    <= sum_in;
      first_ff  <= first_in;
      meta_ff   <= meta_in;
      approx_ff <= approx_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_meta   = meta_ff;
   assign rsp_approx = approx_ff;

endmodule

// ===== rtl/greedy_signed_power_of_two_recoder.sv =====
// Top level of the greedy signed power-of-two recoder.
// Depends on gspt_pkg, gspt_front, gspt_queue and gspt_engine.
//
// Usage:
//   req_*  : one signed fixed-point word per accepted transfer (value in
//            req_tdata). A front end splits it into sign and magnitude and
//            parks it in a two-entry queue, so req_tready stays high while
//            the queue has room.
//   rsp_*  : one word per signed power-of-two digit, rsp_tlast on the final
//            one, which also carries the approximation and bit counts. A zero
//            input yields a single word flagged no_digit.
//   csr_*  : term_limit (reset 8); the user must write it only while the
//            block is idle, which the block itself does not enforce.
// Sequence: the engine loads a queue entry in ST_IDLE, then for each digit
//   runs a leading-one search (ST_FIND) and a threshold compare and residue
//   update (ST_STEP); it takes no new entry until the last digit is issued.
// Reset: synchronous; clears the queue, the engine state and rsp_tvalid.
// Stall: a word held in the output register waits for rsp_tready; the engine
//   pauses and the queue keeps accepting input until it is full.
module greedy_signed_power_of_two_recoder #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16,
   parameter int MAX_TERMS     = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // value
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]          req_tdata,
   // digit_power, approx_value, integer_bits, fraction_bits
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((VALUE_WIDTH+26)/8)*8-1:0]         rsp_tdata,
   // digit_negative, no_digit
   output logic [1:0]                                rsp_tuser,
   output logic                                      rsp_tlast,
   input  logic                                      csr_wr_en,
   input  logic [gspt_pkg::LIMIT_WIDTH-1:0]          csr_wr_data
);

   localparam int CNT_WIDTH = $clog2(MAX_TERMS + 1);
   localparam int QW        = CNT_WIDTH + VALUE_WIDTH + 2;
   localparam int OUT_W     = ((VALUE_WIDTH + 26) / 8) * 8;
   localparam int USED_W    = gspt_pkg::POWER_WIDTH + VALUE_WIDTH + 2
                              + 2 * gspt_pkg::COUNT_FIELD_WIDTH;

   logic [gspt_pkg::LIMIT_WIDTH-1:0] term_limit_ff;
   logic [QW-1:0]                    entry;
   logic                             q_push;
   logic                             q_ready;
   logic                             q_valid;
   logic                             q_pop;
   logic [QW-1:0]                    q_data;
   gspt_pkg::result_meta_type        meta;
   logic [VALUE_WIDTH+1:0]           approx;
   logic [USED_W-1:0]                packed_out;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         term_limit_ff <= gspt_pkg::TERM_LIMIT_RESET;
      end else if (csr_wr_en) begin
         term_limit_ff <= csr_wr_data;
      end
   end

   gspt_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_TERMS   (MAX_TERMS),
      .CNT_WIDTH   (CNT_WIDTH)
   ) u_front (
      .value      (req_tdata[VALUE_WIDTH-1:0]),
      .term_limit (term_limit_ff),
      .entry      (entry)
   );

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   gspt_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   gspt_engine #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_TERMS     (MAX_TERMS),
      .CNT_WIDTH     (CNT_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_meta   (meta),
      .rsp_approx (approx)
   );

   // result word packing
   assign packed_out = {meta.fraction_bits, meta.integer_bits, approx, meta.digit_power};
   assign rsp_tdata  = OUT_W'(packed_out);
   assign rsp_tuser  = {meta.no_digit, meta.digit_negative};
   assign rsp_tlast  = meta.last_digit;

endmodule

// ===== rtl/gspt_checker.sv =====
// Port-level checker for the recoder, bound to the top level below.
// Depends on greedy_signed_power_of_two_recoder's port list.
module gspt_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((VALUE_WIDTH+26)/8)*8-1:0] rsp_tdata,
   input logic [1:0]                        rsp_tuser,
   input logic                              rsp_tlast
);

   localparam int OUT_W = ((VALUE_WIDTH + 26) / 8) * 8;
   localparam int PW    = gspt_pkg::POWER_WIDTH;

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word offered after reset");

   // a stalled word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // an empty result is final and carries nothing else
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0] && (rsp_tdata == '0))
      else $error("empty result malformed");

   // summary fields are zero on all but the final word
   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[OUT_W-1:PW] == '0))
      else $error("summary fields set on a non-final word");

endmodule

bind greedy_signed_power_of_two_recoder gspt_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_gspt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
